[src/kwm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg
// Types and constants shared by the sorted-merge cells and the top level.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int MAX_STREAMS = 16;
   localparam int VALUE_BITS  = 32;
   localparam int IDX_BITS    = 4;
   localparam int CNT_BITS    = $clog2(MAX_STREAMS + 1);
   localparam int CSR_BITS    = 5;

   typedef struct packed {
      logic [IDX_BITS-1:0]          stream_index;
      logic signed [VALUE_BITS-1:0] element_value;
      logic                         stream_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] merged_value;
      logic [IDX_BITS-1:0]          source_stream;
      logic                         merge_done;
   } rsp_type;

   // Running summary that travels down the row of cells, one cell per cycle.
   typedef struct packed {
      logic                         valid;
      logic                         ready;
      logic                         all_ended;
      logic                         found;
      logic signed [VALUE_BITS-1:0] best_value;
      logic [IDX_BITS-1:0]          best_index;
   } scan_type;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic                         wr_en;
      logic [IDX_BITS-1:0]          wr_index;
      logic signed [VALUE_BITS-1:0] wr_value;
      logic                         wr_end;
      logic                         pop_en;
      logic [IDX_BITS-1:0]          pop_index;
      logic                         clear_all;
      logic [CNT_BITS-1:0]          active_count;
   } cell_cmd_type;

endpackage : kwm_pkg
`default_nettype wire

[src/kwm_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_cell
// One stream slot: holds its pending head and flags, and folds them into the
// scan summary that it passes to the next cell.
// ----------------------------------------------------------------------------
module kwm_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire  [kwm_pkg::IDX_BITS-1:0] cell_id,
   input  kwm_pkg::cell_cmd_type        cmd,
   input  kwm_pkg::scan_type            scan_in,
   output kwm_pkg::scan_type            scan_out
);
   import kwm_pkg::*;

   logic signed [VALUE_BITS-1:0] head_ff;
   logic                         present_ff, present_in;
   logic                         finished_ff, finished_in;
   scan_type                     scan_ff, scan_in_next;
   logic                         active;
   logic                         wr_hit;

   assign active = ({1'b0, cell_id} < CNT_BITS'(cmd.active_count)) &&
                   (int'(cell_id) < int'(cmd.active_count));
   assign wr_hit = cmd.wr_en && (cmd.wr_index == cell_id) && active &&
                   !present_ff && !finished_ff;

   always_comb begin
      present_in  = present_ff;
      finished_in = finished_ff;
      if (cmd.clear_all) begin
         present_in  = 1'b0;
         finished_in = 1'b0;
      end else if (cmd.pop_en && (cmd.pop_index == cell_id)) begin
         present_in = 1'b0;
      end else if (wr_hit) begin
         if (cmd.wr_end) begin
            finished_in = 1'b1;
         end else begin
            present_in = 1'b1;
         end
      end
   end

   always_comb begin
      scan_in_next = scan_in;
      if (scan_in.valid && active) begin
         scan_in_next.ready     = scan_in.ready && (present_ff || finished_ff);
         scan_in_next.all_ended = scan_in.all_ended && finished_ff;
         if (present_ff && (!scan_in.found || (head_ff < scan_in.best_value))) begin
            scan_in_next.found      = 1'b1;
            scan_in_next.best_value = head_ff;
            scan_in_next.best_index = cell_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= 1'b0;
         finished_ff <= 1'b0;
         scan_ff     <= '0;
      end else begin
         present_ff  <= present_in;
         finished_ff <= finished_in;
         scan_ff     <= scan_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit && !cmd.wr_end) begin
         head_ff <= cmd.wr_value;
      end
   end

   assign scan_out = scan_ff;

endmodule : kwm_cell
`default_nettype wire

[src/k_way_sorted_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges up to MAX_STREAMS ascending streams of signed values into one
// ascending stream, emitting the smallest pending head once every stream in
// use holds a head or has ended, and a done item when all have ended.
// ----------------------------------------------------------------------------
// Each accepted item is written into its stream's cell, and then a scan wave
// walks down the row of cells, one cell per cycle, collecting readiness and
// the smallest head (ties go to the lower stream number). An item is not
// taken until the scan wave for the one before has passed the whole cell row
// and its result, if any, has been handed to the output register. A
// result waits in an output register, so a stalled consumer does not stop the
// next item from being accepted until the following result is due.
module k_way_sorted_merge (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  kwm_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output kwm_pkg::rsp_type             rsp_data,
   input  wire                          csr_wr_en,
   input  wire  [kwm_pkg::CSR_BITS-1:0] csr_wr_data
);
   import kwm_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CSR_BITS-1:0] csr_ff;
   logic                start_ff;
   scan_type            result_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [CNT_BITS-1:0] active_count;
   logic                accept;
   logic                emit;
   cell_cmd_type        cmd;
   scan_type            chain [0:MAX_STREAMS];

   always_comb begin
      if (csr_ff == '0) begin
         active_count = CNT_BITS'(1);
      end else if (int'(csr_ff) > MAX_STREAMS) begin
         active_count = CNT_BITS'(MAX_STREAMS);
      end else begin
         active_count = CNT_BITS'(csr_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit      = (state_ff == ST_EMIT) && result_ff.ready &&
                      (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd.wr_en        = accept;
      cmd.wr_index     = req_data.stream_index;
      cmd.wr_value     = req_data.element_value;
      cmd.wr_end       = req_data.stream_end;
      cmd.clear_all    = emit && result_ff.all_ended;
      cmd.pop_en       = emit && !result_ff.all_ended && result_ff.found;
      cmd.pop_index    = result_ff.best_index;
      cmd.active_count = active_count;
   end

   assign chain[0] = '{valid: start_ff, ready: 1'b1, all_ended: 1'b1, found: 1'b0,
                       best_value: '0, best_index: '0};

   for (genvar g = 0; g < MAX_STREAMS; g++) begin : g_cell
      kwm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (IDX_BITS'(g)),
         .cmd      (cmd),
         .scan_in  (chain[g]),
         .scan_out (chain[g+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chain[MAX_STREAMS].valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!result_ff.ready || emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (result_ff.all_ended) begin
            rsp_data_in.merged_value  = '0;
            rsp_data_in.source_stream = '0;
            rsp_data_in.merge_done    = 1'b1;
         end else begin
            rsp_data_in.merged_value  = result_ff.best_value;
            rsp_data_in.source_stream = result_ff.best_index;
            rsp_data_in.merge_done    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= CSR_BITS'(MAX_STREAMS);
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= accept;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if ((state_ff == ST_SCAN) && chain[MAX_STREAMS].valid) begin
         result_ff <= chain[MAX_STREAMS];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : k_way_sorted_merge
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for k_way_sorted_merge. Sorted streams with random
// content are fed one item at a time. Each refill goes to a stream that a
// local merge predictor says is waiting for a head. Dropped items, register
// changes during a merge, ties and value extremes are mixed in. Every result
// is checked field by field against the predicted merge order, while both
// sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import kwm_pkg::*;

   localparam int LANE_DEPTH     = 8;
   localparam int SETTLE_CYCLES  = 3 * (MAX_STREAMS + 3);
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 400;
   localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [CSR_BITS-1:0] csr_wr_data;

   logic [CSR_BITS-1:0]          streams_reg;
   logic signed [VALUE_BITS-1:0] head_value [MAX_STREAMS];
   bit                           head_held [MAX_STREAMS];
   bit                           lane_ended [MAX_STREAMS];
   rsp_type                      merged_due [$];

   int error_count;
   int item_count;
   int idle_count;
   int rsp_gap;
   int hold_left;
   bit quiet;
   bit hold_request;

   k_way_sorted_merge u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int streams_active();
      int n;
      n = int'(streams_reg);
      if (n == 0) n = 1;
      else if (n > MAX_STREAMS) n = MAX_STREAMS;
      return n;
   endfunction

   function automatic void clear_merge_state();
      for (int i = 0; i < MAX_STREAMS; i++) begin
         head_value[i] = '0;
         head_held[i]  = 1'b0;
         lane_ended[i] = 1'b0;
      end
   endfunction

   // Applies one accepted item and returns 1 with the expected result if the
   // merge emits on this step.
   function automatic bit merge_predict(input req_type item, output rsp_type res);
      int n;
      int lane;
      int best;
      bit all_done;
      n        = streams_active();
      lane     = int'(item.stream_index);
      all_done = 1'b1;
      best     = -1;
      res      = '0;
      if (lane < n && !head_held[lane] && !lane_ended[lane]) begin
         if (item.stream_end) begin
            lane_ended[lane] = 1'b1;
         end else begin
            head_value[lane] = item.element_value;
            head_held[lane]  = 1'b1;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (!head_held[i] && !lane_ended[i]) return 1'b0;
         if (!lane_ended[i]) all_done = 1'b0;
      end
      if (all_done) begin
         clear_merge_state();
         res.merge_done = 1'b1;
         return 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         if (head_held[i] && (best < 0 || head_value[i] < head_value[best])) best = i;
      end
      head_held[best]   = 1'b0;
      res.merged_value  = head_value[best];
      res.source_stream = best[IDX_BITS-1:0];
      return 1'b1;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return MOST_NEG;
         1: return MOST_POS;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_type item, output rsp_type res, output bit emits);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
      emits = merge_predict(item, res);
      if (emits) merged_due = {merged_due, res};
   endtask

   task automatic drive(input int lane, input logic signed [VALUE_BITS-1:0] value,
                        input bit ends);
      req_type item;
      rsp_type res;
      bit      emits;
      item.stream_index  = lane[IDX_BITS-1:0];
      item.element_value = value;
      item.stream_end    = ends;
      send_item(item, res, emits);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (merged_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_streams(input logic [CSR_BITS-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      streams_reg = value;
   endtask

   // Feeds ascending streams until the done item, refilling whichever stream
   // the predictor says is waiting, with occasional stray items mixed in.
   task automatic run_merge(input int max_len, input bit narrow);
      logic signed [VALUE_BITS-1:0] lane_vals [MAX_STREAMS][LANE_DEPTH];
      int      lane_len [MAX_STREAMS];
      int      lane_pos [MAX_STREAMS];
      int      open_lanes [$];
      int      n;
      int      s;
      longint  cur;
      req_type item;
      rsp_type res;
      bit      emits;
      bit      finished_merge;
      n = streams_active();
      for (s = 0; s < n; s++) begin
         lane_len[s] = $urandom_range(0, max_len);
         lane_pos[s] = 0;
         if (narrow) cur = longint'(int'($urandom_range(0, 4)) - 3);
         else if ($urandom_range(0, 3) == 0) cur = longint'(MOST_NEG);
         else cur = longint'($signed($urandom));
         for (int k = 0; k < lane_len[s]; k++) begin
            lane_vals[s][k] = cur[VALUE_BITS-1:0];
            if (narrow) cur += longint'($urandom_range(0, 1));
            else cur += longint'($urandom_range(0, 32'h07ff_ffff));
            if (cur > longint'(MOST_POS)) cur = longint'(MOST_POS);
         end
      end
      finished_merge = 1'b0;
      while (!finished_merge) begin
         open_lanes.delete();
         for (s = 0; s < n; s++) begin
            if (!head_held[s] && !lane_ended[s]) open_lanes = {open_lanes, s};
         end
         item.element_value = rand_value();
         item.stream_end    = 1'b0;
         if (open_lanes.size() == 0 || $urandom_range(0, 9) == 0) begin
            item.stream_index = IDX_BITS'($urandom_range(0, MAX_STREAMS - 1));
            item.stream_end   = 1'($urandom_range(0, 1));
         end else begin
            s = open_lanes[$urandom_range(0, open_lanes.size() - 1)];
            item.stream_index = s[IDX_BITS-1:0];
            if (lane_pos[s] < lane_len[s]) begin
               item.element_value = lane_vals[s][lane_pos[s]];
               lane_pos[s]++;
            end else begin
               item.stream_end = 1'b1;
            end
         end
         send_item(item, res, emits);
         finished_merge = emits && res.merge_done;
      end
   endtask

   task automatic test_directed_edges();
      write_streams(5'd2);
      drive(0, MOST_POS, 1'b0);
      drive(0, 7, 1'b0);
      drive(5, 1, 1'b0);
      drive(1, MOST_NEG, 1'b0);
      drive(1, MOST_NEG, 1'b0);
      drive(1, MOST_POS, 1'b0);
      drive(0, -1, 1'b1);
      drive(0, 3, 1'b0);
      drive(1, 0, 1'b1);
      write_streams(5'd0);
      drive(15, -1, 1'b0);
      drive(0, 42, 1'b0);
      drive(0, 0, 1'b1);
      write_streams(5'd31);
      run_merge(1, 1'b0);
   endtask

   task automatic test_config_change();
      write_streams(5'd4);
      drive(0, 10, 1'b0);
      drive(1, 20, 1'b0);
      drive(2, 0, 1'b1);
      write_streams(5'd3);
      drive(0, 99, 1'b0);
      run_merge(4, 1'b0);
   endtask

   task automatic test_random_merges();
      int                  start;
      int                  n;
      logic [CSR_BITS-1:0] count;
      start = item_count;
      while (item_count - start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: count = 5'd1;
            1: count = CSR_BITS'(MAX_STREAMS);
            2: count = CSR_BITS'($urandom_range(MAX_STREAMS + 1, 31));
            3: count = 5'd0;
            default: count = CSR_BITS'($urandom_range(2, MAX_STREAMS - 1));
         endcase
         write_streams(count);
         n = streams_active();
         run_merge(n > 8 ? 3 : LANE_DEPTH, $urandom_range(0, 2) == 0);
      end
   endtask

   task automatic test_random_items();
      req_type item;
      rsp_type res;
      bit      emits;
      write_streams(CSR_BITS'($urandom_range(1, MAX_STREAMS)));
      for (int k = 0; k < 40; k++) begin
         item.stream_index  = IDX_BITS'($urandom_range(0, MAX_STREAMS - 1));
         item.element_value = rand_value();
         item.stream_end    = ($urandom_range(0, 3) == 0);
         send_item(item, res, emits);
      end
      run_merge(2, 1'b0);
   endtask

   task automatic test_output_stall();
      write_streams(CSR_BITS'(MAX_STREAMS));
      @(posedge clock);
      hold_request = 1'b1;
      run_merge(4, 1'b0);
   endtask

   task automatic test_quiet_tail();
      @(posedge clock);
      quiet = 1'b1;
      for (int k = 0; k < 3; k++) begin
         write_streams(CSR_BITS'($urandom_range(1, MAX_STREAMS)));
         run_merge(3, k == 1);
      end
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (merged_due.size() == 0) begin
            $display("%0t: result with nothing expected: value %0d stream %0d done %0b",
                     $time, rsp_data.merged_value, rsp_data.source_stream,
                     rsp_data.merge_done);
            error_count++;
         end else begin
            want = merged_due.pop_front();
            if (rsp_data.merged_value !== want.merged_value) begin
               $display("%0t: merged_value expected %0d actual %0d", $time,
                        want.merged_value, rsp_data.merged_value);
               error_count++;
            end
            if (rsp_data.source_stream !== want.source_stream) begin
               $display("%0t: source_stream expected %0d actual %0d", $time,
                        want.source_stream, rsp_data.source_stream);
               error_count++;
            end
            if (rsp_data.merge_done !== want.merge_done) begin
               $display("%0t: merge_done expected %0b actual %0b", $time,
                        want.merge_done, rsp_data.merge_done);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else if (idle_count == WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      streams_reg = CSR_BITS'(MAX_STREAMS);
      clear_merge_state();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_config_change();
      test_random_merges();
      test_random_items();
      test_output_stall();
      test_quiet_tail();
      wait_drained();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
src/kwm_pkg.sv
src/kwm_cell.sv
src/k_way_sorted_merge.sv
test/tb_top.sv
